// ===== rtl/jlr_pkg.sv =====
// ----------------------------------------------------------------------------
// jlr_pkg
// Shared types and constants for the Jacobi five-point relaxation core.
// ----------------------------------------------------------------------------
package jlr_pkg;

    localparam int VALUE_BITS   = 24;
    localparam int IDX_BITS     = 8;
    localparam int CFG_BITS     = 9;
    localparam int CFG_IDX_BITS = 1;
    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 256;

    typedef enum logic [1:0] {
        K_WRITE  = 2'd0,
        K_READ   = 2'd1,
        K_RELAX  = 2'd2,
        K_COMMIT = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLS = 1'b1;

    typedef struct packed {
        logic                go;
        logic [IDX_BITS-1:0] first_row;
        logic [IDX_BITS-1:0] last_row;
    } t_relax_cmd;

    typedef struct packed {
        logic active;
        logic done;
    } t_sweep_stat;

endpackage

// ===== rtl/jlr_ram.sv =====
// ----------------------------------------------------------------------------
// jlr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module jlr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/jlr_sweep.sv =====
// ----------------------------------------------------------------------------
// jlr_sweep
// Relaxation sequencer: reads the four wrap-around neighbours of each cell
// from the current grid, sums them and writes the floored quarter to the
// next grid.
// ----------------------------------------------------------------------------
module jlr_sweep #(
    parameter int MAX_ROWS = jlr_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = jlr_pkg::MAX_COLS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  jlr_pkg::t_relax_cmd                      i_cmd,
    input  logic [$clog2(MAX_ROWS+1)-1:0]            i_rows_in_use,
    input  logic [$clog2(MAX_COLS+1)-1:0]            i_cols_in_use,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]     o_raddr,
    input  logic [jlr_pkg::VALUE_BITS-1:0]           i_rdata,
    output logic                                     o_we,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]     o_waddr,
    output logic [jlr_pkg::VALUE_BITS-1:0]           o_wdata,
    output jlr_pkg::t_sweep_stat                     o_stat
);

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
    localparam int ACC_W  = jlr_pkg::VALUE_BITS + 2;

    localparam logic [1:0] PH_LEFT  = 2'd0;
    localparam logic [1:0] PH_UP    = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;
    localparam logic [1:0] PH_DOWN  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    t_state                  r_state;
    logic [ROW_W-1:0]        r_row;
    logic [ROW_W-1:0]        r_last;
    logic [COL_W-1:0]        r_col;
    logic [1:0]              r_ph;
    logic                    r_v1;
    logic [1:0]              r_ph1;
    logic [ADDR_W-1:0]       r_addr1;
    logic signed [ACC_W-1:0] r_acc;

    logic [ROW_W-1:0]        rows_m1;
    logic [COL_W-1:0]        cols_m1;
    logic [ROW_W-1:0]        up_row;
    logic [ROW_W-1:0]        dn_row;
    logic [COL_W-1:0]        lf_col;
    logic [COL_W-1:0]        rt_col;
    logic [ROW_W-1:0]        rd_row;
    logic [COL_W-1:0]        rd_col;
    logic [ADDR_W-1:0]       cell_addr;
    logic signed [ACC_W-1:0] rd_ext;
    logic signed [ACC_W-1:0] sum;
    logic                    col_end;
    logic                    row_end;

    assign rows_m1 = ROW_W'(i_rows_in_use - 1'b1);
    assign cols_m1 = COL_W'(i_cols_in_use - 1'b1);
    assign up_row  = (r_row == '0) ? rows_m1 : ROW_W'(r_row - 1'b1);
    assign dn_row  = (r_row == rows_m1) ? '0 : ROW_W'(r_row + 1'b1);
    assign lf_col  = (r_col == '0) ? cols_m1 : COL_W'(r_col - 1'b1);
    assign rt_col  = (r_col == cols_m1) ? '0 : COL_W'(r_col + 1'b1);
    assign col_end = (r_col == cols_m1);
    assign row_end = (r_row == r_last);

    always_comb begin
        rd_row = r_row;
        rd_col = r_col;
        case (r_ph)
            PH_LEFT:  rd_col = lf_col;
            PH_UP:    rd_row = up_row;
            PH_RIGHT: rd_col = rt_col;
            PH_DOWN:  rd_row = dn_row;
            default:  rd_col = r_col;
        endcase
    end

    assign o_raddr   = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(MAX_COLS) + ADDR_W'(rd_col));
    assign cell_addr = ADDR_W'(ADDR_W'(r_row) * ADDR_W'(MAX_COLS) + ADDR_W'(r_col));

    assign rd_ext  = ACC_W'($signed(i_rdata));
    assign sum     = r_acc + rd_ext;
    assign o_we    = r_v1 && (r_ph1 == PH_DOWN);
    assign o_waddr = r_addr1;
    assign o_wdata = jlr_pkg::VALUE_BITS'(sum >>> 2);

    assign o_stat.active = (r_state != S_IDLE);
    assign o_stat.done   = (r_state == S_DRAIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_ph    <= PH_LEFT;
        end else begin
            // neighbour accumulation, one read per cycle
            if (r_v1) begin
                r_acc <= (r_ph1 == PH_LEFT) ? rd_ext : sum;
            end
            case (r_state)
                S_IDLE: begin
                    r_v1 <= 1'b0;
                    if (i_cmd.go) begin
                        r_row   <= ROW_W'(i_cmd.first_row);
                        r_last  <= ROW_W'(i_cmd.last_row);
                        r_col   <= '0;
                        r_ph    <= PH_LEFT;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_v1    <= 1'b1;
                    r_ph1   <= r_ph;
                    r_addr1 <= cell_addr;
                    r_ph    <= r_ph + 2'd1;
                    if (r_ph == PH_DOWN) begin
                        if (col_end) begin
                            r_col <= '0;
                            r_row <= ROW_W'(r_row + 1'b1);
                            if (row_end) begin
                                r_state <= S_DRAIN;
                            end
                        end else begin
                            r_col <= COL_W'(r_col + 1'b1);
                        end
                    end
                end
                S_DRAIN: begin
                    r_v1    <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_v1    <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/jacobi_laplace_relaxation_core.sv =====
// ----------------------------------------------------------------------------
// jacobi_laplace_relaxation_core
// Jacobi relaxation of a wrap-around potential grid with the five-point
// Laplace stencil, kept in two grid RAMs that swap roles on commit.
// ----------------------------------------------------------------------------
// write, read, commit and rejected requests: one per cycle while o_busy is low, o_done
//   in the cycle after the request is taken
// relax: the four neighbours of each cell are read in turn through the single read
//   port of the current grid; o_done comes after the sweep ends, o_busy high until then
// reset: sizes in use go to the maximum, grid A is current, grid RAMs keep
//   their contents; no result is pending after reset
module jacobi_laplace_relaxation_core #(
    parameter int MAX_ROWS = jlr_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = jlr_pkg::MAX_COLS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic [1:0]                             i_kind,
    input  logic [jlr_pkg::IDX_BITS-1:0]           i_row,
    input  logic [jlr_pkg::IDX_BITS-1:0]           i_col,
    input  logic [jlr_pkg::IDX_BITS-1:0]           i_last_row,
    input  logic signed [jlr_pkg::VALUE_BITS-1:0]  i_cell_value,
    output logic                                   o_done,
    output logic signed [jlr_pkg::VALUE_BITS-1:0]  o_read_value,
    output logic                                   o_range_error,
    input  logic                                   i_cfg_we,
    input  logic [jlr_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [jlr_pkg::CFG_BITS-1:0]           i_cfg_data
);

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ADDR_W  = $clog2(MAX_ROWS * MAX_COLS);
    localparam int RSIZE_W = $clog2(MAX_ROWS + 1);
    localparam int CSIZE_W = $clog2(MAX_COLS + 1);
    localparam int CW0     = (RSIZE_W > CSIZE_W) ? RSIZE_W : CSIZE_W;
    localparam int CW      = (CW0 > jlr_pkg::CFG_BITS) ? CW0 : jlr_pkg::CFG_BITS;
    localparam int VB      = jlr_pkg::VALUE_BITS;

    logic [RSIZE_W-1:0] r_rows;
    logic [CSIZE_W-1:0] r_cols;
    logic               r_sel;
    logic               r_out_valid;
    logic               r_out_err;
    logic               r_out_read;
    logic               r_out_sel;

    jlr_pkg::t_kind       kind;
    jlr_pkg::t_relax_cmd  cmd;
    jlr_pkg::t_sweep_stat stat;

    logic              accept;
    logic              cell_err;
    logic              relax_err;
    logic              err;
    logic              host_we;
    logic [ADDR_W-1:0] host_addr;
    logic [CW-1:0]     cfg_ext;
    logic [CW-1:0]     rows_ext;
    logic [CW-1:0]     cols_ext;
    logic [CW-1:0]     n_size;

    logic [ADDR_W-1:0] sw_raddr;
    logic              sw_we;
    logic [ADDR_W-1:0] sw_waddr;
    logic [VB-1:0]     sw_wdata;
    logic [VB-1:0]     sw_rdata;

    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] waddr;
    logic [VB-1:0]     wdata;
    logic [ADDR_W-1:0] raddr;
    logic [VB-1:0]     rdata_a;
    logic [VB-1:0]     rdata_b;

    assign kind     = jlr_pkg::t_kind'(i_kind);
    assign accept   = i_start && !stat.active;
    assign rows_ext = CW'(r_rows);
    assign cols_ext = CW'(r_cols);

    assign cell_err  = (CW'(i_row) >= rows_ext) || (CW'(i_col) >= cols_ext);
    assign relax_err = (i_row > i_last_row) || (CW'(i_last_row) >= rows_ext);

    always_comb begin
        case (kind)
            jlr_pkg::K_WRITE:  err = cell_err;
            jlr_pkg::K_READ:   err = cell_err;
            jlr_pkg::K_RELAX:  err = relax_err;
            jlr_pkg::K_COMMIT: err = 1'b0;
            default:           err = 1'b0;
        endcase
    end

    assign host_addr = ADDR_W'(ADDR_W'(ROW_W'(i_row)) * ADDR_W'(MAX_COLS)
                       + ADDR_W'(COL_W'(i_col)));
    assign host_we   = accept && (kind == jlr_pkg::K_WRITE) && !cell_err;

    assign cmd.go        = accept && (kind == jlr_pkg::K_RELAX) && !relax_err;
    assign cmd.first_row = i_row;
    assign cmd.last_row  = i_last_row;

    // size register clamp: zero means one, above the maximum means the maximum
    assign cfg_ext = CW'(i_cfg_data);
    always_comb begin
        n_size = cfg_ext;
        if (cfg_ext == '0) begin
            n_size = CW'(1);
        end else if ((i_cfg_index == jlr_pkg::CFG_ROWS) && (cfg_ext > CW'(MAX_ROWS))) begin
            n_size = CW'(MAX_ROWS);
        end else if ((i_cfg_index == jlr_pkg::CFG_COLS) && (cfg_ext > CW'(MAX_COLS))) begin
            n_size = CW'(MAX_COLS);
        end
    end

    // current grid is read; writes go to current for requests, next for the sweep
    assign we_a  = (host_we && !r_sel) || (sw_we && r_sel);
    assign we_b  = (host_we && r_sel) || (sw_we && !r_sel);
    assign waddr = stat.active ? sw_waddr : host_addr;
    assign wdata = stat.active ? sw_wdata : VB'(i_cell_value);
    assign raddr = stat.active ? sw_raddr : host_addr;
    assign sw_rdata = r_sel ? rdata_b : rdata_a;

    jlr_ram #(
        .WIDTH (VB),
        .DEPTH (MAX_ROWS * MAX_COLS)
    ) u_grid_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_a)
    );

    jlr_ram #(
        .WIDTH (VB),
        .DEPTH (MAX_ROWS * MAX_COLS)
    ) u_grid_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_b)
    );

    jlr_sweep #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_sweep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rows_in_use (r_rows),
        .i_cols_in_use (r_cols),
        .o_raddr       (sw_raddr),
        .i_rdata       (sw_rdata),
        .o_we          (sw_we),
        .o_waddr       (sw_waddr),
        .o_wdata       (sw_wdata),
        .o_stat        (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= RSIZE_W'(MAX_ROWS);
            r_cols      <= CSIZE_W'(MAX_COLS);
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_err   <= 1'b0;
            r_out_read  <= 1'b0;
            r_out_sel   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    jlr_pkg::CFG_ROWS: r_rows <= RSIZE_W'(n_size);
                    jlr_pkg::CFG_COLS: r_cols <= CSIZE_W'(n_size);
                    default:           r_rows <= r_rows;
                endcase
            end
            if (accept && (kind == jlr_pkg::K_COMMIT)) begin
                r_sel <= ~r_sel;
            end
            r_out_valid <= (accept && !cmd.go) || stat.done;
            r_out_err   <= accept && err;
            r_out_read  <= accept && (kind == jlr_pkg::K_READ) && !cell_err;
            r_out_sel   <= r_sel;
        end
    end

    assign o_busy        = stat.active;
    assign o_done        = r_out_valid;
    assign o_range_error = r_out_err;
    assign o_read_value  = r_out_read ? $signed(r_out_sel ? rdata_b : rdata_a) : '0;

`ifndef NO_ASSERTIONS
    a_request_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_done || o_busy))
        else $error("request neither answered nor started a sweep");

    a_one_grid_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(we_a && we_b))
        else $error("both grids written in one cycle");

    a_select_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_busy && $past(o_busy)) |-> $stable(r_sel))
        else $error("grid select changed during a sweep");

    a_sweep_writes_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sw_we |-> (stat.active && (r_sel ? we_a : we_b)))
        else $error("sweep write not aimed at the next grid");
`endif

endmodule
